// File: hw/rtl/smalu_pkg.sv
// package for the stack machine integer alu
// command and status codes, cell and stack operation types, fsm states
// no dependencies
package smalu_pkg;

    localparam int DEF_STACK_DEPTH = 64;
    localparam int WORD_W          = 32;
    localparam int CMD_W           = 3;
    localparam int STATUS_W        = 2;
    localparam int COUNT_W         = 7;

    localparam logic [CMD_W-1:0] CMD_ADD  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIV  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REM  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PUSH = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_DIVZERO   = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_DOWN,
        CELL_UP1,
        CELL_UP2
    } cell_op_t;

    typedef enum logic [2:0] {
        STK_HOLD,
        STK_PUSH,
        STK_POP1,
        STK_POP2,
        STK_COMBINE
    } stk_op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic want_rem;
    } div_ctl_t;

    function automatic logic [WORD_W-1:0] mag32(input logic [WORD_W-1:0] v);
        mag32 = v[WORD_W-1] ? (~v + WORD_W'(1)) : v;
    endfunction

endpackage

// File: hw/rtl/smalu_cell.sv
// one stack cell: holds a word and takes it from a neighbor on shifts
// depends on smalu_pkg
module smalu_cell (
    input  logic                               aclk,
    input  smalu_pkg::cell_op_t                op,
    input  logic [smalu_pkg::WORD_W-1:0]       d_prev,
    input  logic [smalu_pkg::WORD_W-1:0]       d_next1,
    input  logic [smalu_pkg::WORD_W-1:0]       d_next2,
    output logic [smalu_pkg::WORD_W-1:0]       q
);
    import smalu_pkg::*;

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    always_comb begin
        unique case (op)
            CELL_HOLD: word_next = word_reg;
            CELL_DOWN: word_next = d_prev;
            CELL_UP1:  word_next = d_next1;
            CELL_UP2:  word_next = d_next2;
            default:   word_next = word_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign q = word_reg;

endmodule

// File: hw/rtl/smalu_div.sv
// iterative radix-2 signed divider, truncating, one quotient bit per cycle
// depends on smalu_pkg
module smalu_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  smalu_pkg::div_ctl_t                ctl,
    input  logic [smalu_pkg::WORD_W-1:0]       dividend,
    input  logic [smalu_pkg::WORD_W-1:0]       divisor,
    output logic                               done,
    output logic [smalu_pkg::WORD_W-1:0]       result
);
    import smalu_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);

    logic              run_reg, run_next;
    logic              fin_reg, fin_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] dvs_reg, dvs_next;
    logic [WORD_W-1:0] res_reg, res_next;
    logic              neg_a_reg, neg_a_next;
    logic              neg_q_reg, neg_q_next;
    logic              want_rem_reg, want_rem_next;

    logic [WORD_W-1:0] shifted;
    logic [WORD_W:0]   trial;

    assign shifted = {rem_reg[WORD_W-2:0], quo_reg[WORD_W-1]};
    assign trial   = {1'b0, shifted} - {1'b0, dvs_reg};

    always_comb begin
        run_next      = run_reg;
        fin_next      = 1'b0;
        done_next     = 1'b0;
        cnt_next      = cnt_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        dvs_next      = dvs_reg;
        res_next      = res_reg;
        neg_a_next    = neg_a_reg;
        neg_q_next    = neg_q_reg;
        want_rem_next = want_rem_reg;
        if (ctl.start) begin
            run_next      = 1'b1;
            cnt_next      = '0;
            rem_next      = '0;
            quo_next      = mag32(dividend);
            dvs_next      = mag32(divisor);
            neg_a_next    = dividend[WORD_W-1];
            neg_q_next    = dividend[WORD_W-1] ^ divisor[WORD_W-1];
            want_rem_next = ctl.want_rem;
        end else if (run_reg) begin
            if (!trial[WORD_W]) begin
                rem_next = trial[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(WORD_W - 1)) begin
                run_next = 1'b0;
                fin_next = 1'b1;
            end
        end else if (fin_reg) begin
            done_next = 1'b1;
            if (want_rem_reg) begin
                res_next = neg_a_reg ? (~rem_reg + WORD_W'(1)) : rem_reg;
            end else begin
                res_next = neg_q_reg ? (~quo_reg + WORD_W'(1)) : quo_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
        cnt_reg      <= cnt_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        dvs_reg      <= dvs_next;
        res_reg      <= res_next;
        neg_a_reg    <= neg_a_next;
        neg_q_reg    <= neg_q_next;
        want_rem_reg <= want_rem_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// File: hw/rtl/stack_machine_integer_alu_top.sv
// stack machine integer alu, top level: cell row stack, control fsm, alu, divider
// depends on smalu_pkg, smalu_cell, smalu_div
// from input accept to m_tvalid: push, failed and unused commands go from idle straight to done,
//   add, subtract, multiply via exec, divide and remainder via exec and the 32-step radix-2 divider
// one command in flight: a new one is taken once the last result has entered the output register
// synchronous active-low reset empties the stack and clears the output valid
module stack_machine_integer_alu_top #(
    parameter int STACK_DEPTH = smalu_pkg::DEF_STACK_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [31:0]                         s_tdata,  // push_value[31:0]
    input  logic [smalu_pkg::CMD_W-1:0]         s_tuser,  // command[2:0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [39:0]                         m_tdata,  // result_word[31:0], stack_count[38:32]
    output logic [smalu_pkg::STATUS_W-1:0]      m_tuser   // status[1:0]
);
    import smalu_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  new_cnt_reg, new_cnt_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [WORD_W-1:0] a_reg, a_next;
    logic [WORD_W-1:0] b_reg, b_next;
    logic [WORD_W-1:0] res_reg, res_next;
    logic [STATUS_W-1:0] stat_reg, stat_next;
    stk_op_t           op_reg, op_next;
    logic              need_exec_next;
    logic              mv_reg, mv_next;
    logic [39:0]       md_reg, md_next;
    logic [STATUS_W-1:0] mu_reg, mu_next;

    logic              accept;
    logic              out_free;
    logic              commit;
    div_ctl_t          div_ctl;
    logic              div_done;
    logic [WORD_W-1:0] div_res;
    logic [WORD_W-1:0] alu_res;
    logic              is_div;

    logic [WORD_W-1:0] cell_q  [STACK_DEPTH];
    cell_op_t          cell_op [STACK_DEPTH];

    assign out_free = !mv_reg || m_tready;
    assign is_div   = (cmd_reg == CMD_DIV) || (cmd_reg == CMD_REM);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = need_exec_next ? S_EXEC : S_DONE;
                end
            end
            S_EXEC: state_next = is_div ? S_DIV : S_DONE;
            S_DIV: begin
                if (div_done) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        s_tready         = 1'b0;
        div_ctl.start    = 1'b0;
        div_ctl.want_rem = (cmd_reg == CMD_REM);
        commit           = 1'b0;
        unique case (state_reg)
            S_IDLE: s_tready = 1'b1;
            S_EXEC: div_ctl.start = is_div;
            S_DIV:  commit = 1'b0;
            S_DONE: commit = out_free;
            default: s_tready = 1'b0;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // decode on accept
    always_comb begin
        cmd_next       = cmd_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        stat_next      = stat_reg;
        new_cnt_next   = new_cnt_reg;
        op_next        = op_reg;
        need_exec_next = 1'b0;
        if (accept) begin
            cmd_next     = s_tuser;
            a_next       = cell_q[0];
            b_next       = cell_q[1];
            stat_next    = STAT_OK;
            new_cnt_next = cnt_reg;
            op_next      = STK_HOLD;
            if (s_tuser == CMD_PUSH) begin
                if (cnt_reg == CNT_W'(STACK_DEPTH)) begin
                    stat_next = STAT_OVERFLOW;
                end else begin
                    op_next      = STK_PUSH;
                    new_cnt_next = cnt_reg + CNT_W'(1);
                end
            end else if (s_tuser <= CMD_REM) begin
                priority if (cnt_reg == '0) begin
                    stat_next = STAT_UNDERFLOW;
                end else if (cnt_reg == CNT_W'(1)) begin
                    stat_next    = STAT_UNDERFLOW;
                    op_next      = STK_POP1;
                    new_cnt_next = '0;
                end else if (((s_tuser == CMD_DIV) || (s_tuser == CMD_REM))
                             && (cell_q[1] == '0)) begin
                    stat_next    = STAT_DIVZERO;
                    op_next      = STK_POP2;
                    new_cnt_next = cnt_reg - CNT_W'(2);
                end else begin
                    op_next        = STK_COMBINE;
                    new_cnt_next   = cnt_reg - CNT_W'(1);
                    need_exec_next = 1'b1;
                end
            end
        end
    end

    always_comb begin
        unique case (cmd_reg)
            CMD_ADD: alu_res = a_reg + b_reg;
            CMD_SUB: alu_res = a_reg - b_reg;
            CMD_MUL: alu_res = a_reg * b_reg;
            default: alu_res = '0;
        endcase
    end

    always_comb begin
        res_next = res_reg;
        if (accept) begin
            res_next = (s_tuser == CMD_PUSH && cnt_reg != CNT_W'(STACK_DEPTH))
                       ? s_tdata : '0;
        end else if (state_reg == S_EXEC && !is_div) begin
            res_next = alu_res;
        end else if (state_reg == S_DIV && div_done) begin
            res_next = div_res;
        end
    end

    always_comb begin
        mv_next  = mv_reg;
        md_next  = md_reg;
        mu_next  = mu_reg;
        cnt_next = cnt_reg;
        if (m_tready) begin
            mv_next = 1'b0;
        end
        if (commit) begin
            mv_next  = 1'b1;
            md_next  = {1'b0, COUNT_W'(new_cnt_reg), res_reg};
            mu_next  = stat_reg;
            cnt_next = new_cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
        end
        cmd_reg       <= cmd_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        res_reg       <= res_next;
        stat_reg      <= stat_next;
        new_cnt_reg   <= new_cnt_next;
        op_reg        <= op_next;
        md_reg        <= md_next;
        mu_reg        <= mu_next;
    end

    smalu_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .dividend (a_reg),
        .divisor  (b_reg),
        .done     (div_done),
        .result   (div_res)
    );

    // stack as a row of cells, top of stack in cell 0
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        logic [WORD_W-1:0] prev_w;
        logic [WORD_W-1:0] next1_w;
        logic [WORD_W-1:0] next2_w;

        if (i == 0) begin : g_first
            assign prev_w = res_reg;
        end else begin : g_mid
            assign prev_w = cell_q[i-1];
        end
        if (i + 1 < STACK_DEPTH) begin : g_n1
            assign next1_w = cell_q[i+1];
        end else begin : g_n1_end
            assign next1_w = '0;
        end
        if (i + 2 < STACK_DEPTH) begin : g_n2
            assign next2_w = cell_q[i+2];
        end else begin : g_n2_end
            assign next2_w = '0;
        end

        always_comb begin
            cell_op[i] = CELL_HOLD;
            if (commit) begin
                unique case (op_reg)
                    STK_HOLD:    cell_op[i] = CELL_HOLD;
                    STK_PUSH:    cell_op[i] = CELL_DOWN;
                    STK_POP1:    cell_op[i] = CELL_UP1;
                    STK_POP2:    cell_op[i] = CELL_UP2;
                    STK_COMBINE: cell_op[i] = (i == 0) ? CELL_DOWN : CELL_UP1;
                    default:     cell_op[i] = CELL_HOLD;
                endcase
            end
        end

        smalu_cell u_cell (
            .aclk    (aclk),
            .op      (cell_op[i]),
            .d_prev  (prev_w),
            .d_next1 (next1_w),
            .d_next2 (next2_w),
            .q       (cell_q[i])
        );
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mu_reg;

endmodule

// File: hw/rtl/smalu_chk.sv
// port-level checker for the stack machine integer alu, with its bind
// depends on smalu_pkg and stack_machine_integer_alu_top
module smalu_chk (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [31:0]                     s_tdata,
    input logic [smalu_pkg::CMD_W-1:0]     s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [39:0]                     m_tdata,
    input logic [smalu_pkg::STATUS_W-1:0]  m_tuser
);
    import smalu_pkg::*;

    // output empty right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output word changed");

    // failed command returns a zero result word
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != STAT_OK) |-> (m_tdata[31:0] == '0))
        else $error("nonzero result word on failure");

    // one command in flight
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a command is in flight");

endmodule

bind stack_machine_integer_alu_top smalu_chk u_smalu_chk (.*);

// File: sim/testbench.sv
`timescale 1ns / 1ps
// testbench for stack_machine_integer_alu_top: predicts every result word from a shadow stack
// and checks status, pushed word and depth under random idling and a long output stall
// depends on smalu_pkg and stack_machine_integer_alu_top
module testbench;
    import smalu_pkg::*;

    localparam logic [CMD_W-1:0] CMD_NOP6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_NOP7 = 3'd7;
    localparam int DEPTH = DEF_STACK_DEPTH;
    localparam int MAX_PRINTED = 50;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   word;
        logic [COUNT_W-1:0]  count;
    } alu_result_t;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [31:0]         s_tdata  = '0;
    logic [CMD_W-1:0]    s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [39:0]         m_tdata;
    logic [STATUS_W-1:0] m_tuser;

    logic [WORD_W-1:0] shadow_stack [DEPTH];
    int                shadow_depth = 0;
    alu_result_t       results_due [$];

    int errors = 0;
    int checked = 0;
    int tx_max_gap = 0;
    int rx_max_stall = 0;
    int hold_cycles = 0;
    int n_push = 0, n_arith = 0, n_unused = 0;
    int n_underflow = 0, n_overflow = 0, n_divzero = 0, deepest = 0;

    stack_machine_integer_alu_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3ms;
        $display("timeout with %0d words outstanding", results_due.size());
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    function automatic alu_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                  input logic [WORD_W-1:0] value);
        alu_result_t r;
        logic [WORD_W-1:0] a, b, ma, mb;
        r = '0;
        r.status = STAT_OK;
        if (cmd == CMD_PUSH) begin
            n_push++;
            if (shadow_depth >= DEPTH) begin
                r.status = STAT_OVERFLOW;
            end else begin
                shadow_stack[shadow_depth] = value;
                shadow_depth++;
                r.word = value;
            end
        end else if (cmd <= CMD_REM) begin
            n_arith++;
            if (shadow_depth < 2) begin
                shadow_depth = 0;
                r.status = STAT_UNDERFLOW;
            end else begin
                a = shadow_stack[shadow_depth - 1];
                b = shadow_stack[shadow_depth - 2];
                shadow_depth -= 2;
                if ((cmd == CMD_DIV || cmd == CMD_REM) && b == '0) begin
                    r.status = STAT_DIVZERO;
                end else begin
                    ma = a[WORD_W-1] ? -a : a;
                    mb = b[WORD_W-1] ? -b : b;
                    case (cmd)
                        CMD_ADD: r.word = a + b;
                        CMD_SUB: r.word = a - b;
                        CMD_MUL: r.word = a * b;
                        CMD_DIV: r.word = (a[WORD_W-1] ^ b[WORD_W-1]) ? -(ma / mb) : ma / mb;
                        default: r.word = a[WORD_W-1] ? -(ma % mb) : ma % mb;
                    endcase
                    shadow_stack[shadow_depth] = r.word;
                    shadow_depth++;
                end
            end
        end else begin
            n_unused++;
        end
        case (r.status)
            STAT_UNDERFLOW: n_underflow++;
            STAT_OVERFLOW:  n_overflow++;
            STAT_DIVZERO:   n_divzero++;
            default: ;
        endcase
        if (shadow_depth > deepest)
            deepest = shadow_depth;
        r.count = COUNT_W'(shadow_depth);
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return {1'b1, {(WORD_W-1){1'b0}}};
            2: return {1'b0, {(WORD_W-1){1'b1}}};
            3: return '1;
            4, 5: return WORD_W'($urandom_range(0, 40)) - WORD_W'(20);
            default: return $urandom;
        endcase
    endfunction

    task automatic set_idling(input int tx_gap, input int rx_stall);
        tx_max_gap = tx_gap;
        rx_max_stall = rx_stall;
    endtask

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] value);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        results_due.push_back(apply_command(cmd, value));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    // receiver: random stall per word, plus an optional long hold-off
    initial begin
        int stall;
        forever begin
            stall = hold_cycles + $urandom_range(0, rx_max_stall);
            hold_cycles = 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid && hold_cycles == 0) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        alu_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tuser;
            got.word   = m_tdata[31:0];
            got.count  = m_tdata[38:32];
            if (results_due.size() == 0) begin
                report_mismatch($sformatf("unexpected word: status %0d value %h count %0d",
                                          got.status, got.word, got.count));
            end else begin
                want = results_due.pop_front();
                checked++;
                if (got.status != want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              got.status, want.status));
                if (got.word != want.word)
                    report_mismatch($sformatf("result word %h, expected %h",
                                              got.word, want.word));
                if (got.count != want.count)
                    report_mismatch($sformatf("stack count %0d, expected %0d",
                                              got.count, want.count));
            end
        end
    end

    // operands: b is pushed first, a on top
    task automatic test_directed_corners();
        set_idling(2, 2);
        send_word(CMD_ADD, '0);
        send_word(CMD_PUSH, 32'd123);
        send_word(CMD_MUL, '0);
        send_word(CMD_PUSH, 32'h7fffffff);
        send_word(CMD_PUSH, 32'd1);
        send_word(CMD_ADD, '1);
        send_word(CMD_PUSH, 32'd1);
        send_word(CMD_SUB, '0);
        send_word(CMD_PUSH, 32'd0);
        send_word(CMD_PUSH, 32'd9);
        send_word(CMD_DIV, '0);
        send_word(CMD_PUSH, 32'd0);
        send_word(CMD_PUSH, 32'd9);
        send_word(CMD_REM, '0);
        send_word(CMD_PUSH, 32'hffffffff);
        send_word(CMD_PUSH, 32'h80000000);
        send_word(CMD_DIV, '0);
        send_word(CMD_PUSH, 32'hffffffff);
        send_word(CMD_PUSH, 32'h80000000);
        send_word(CMD_REM, '0);
        send_word(CMD_PUSH, 32'd2);
        send_word(CMD_PUSH, -32'sd7);
        send_word(CMD_DIV, '0);
        send_word(CMD_PUSH, 32'd2);
        send_word(CMD_PUSH, -32'sd7);
        send_word(CMD_REM, '0);
        send_word(CMD_NOP6, '1);
        send_word(CMD_NOP7, '0);
    endtask

    // fill the stack past full while the output is held off, then reduce it again
    task automatic test_fill_and_stall();
        set_idling(0, 4);
        hold_cycles = 500;
        while (shadow_depth < DEPTH)
            send_word(CMD_PUSH, rand_word());
        send_word(CMD_PUSH, $urandom);
        send_word(CMD_PUSH, $urandom);
        set_idling(8, 8);
        while (shadow_depth > 1)
            send_word(CMD_W'($urandom_range(CMD_ADD, CMD_REM)), $urandom);
    endtask

    task automatic test_random_mix(input int n_items);
        int pick;
        for (int i = 0; i < n_items; i++) begin
            if (i % 100 == 0) begin
                case ((i / 100) % 4)
                    0: set_idling(16, 16);
                    1: set_idling(0, 0);
                    2: set_idling(0, 16);
                    default: set_idling(16, 0);
                endcase
            end
            pick = $urandom_range(0, 99);
            if (pick < 3)
                send_word($urandom_range(0, 1) ? CMD_NOP6 : CMD_NOP7, $urandom);
            else if ((shadow_depth < 2 && pick < 90) || (shadow_depth < DEPTH - 4 && pick < 48)
                     || pick > 96)
                send_word(CMD_PUSH, rand_word());
            else
                send_word(CMD_W'($urandom_range(CMD_ADD, CMD_REM)), $urandom);
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_corners();
        wait_drained();
        test_fill_and_stall();
        wait_drained();
        test_random_mix(350);
        wait_drained();
        $display("%0d commands sent (%0d push, %0d arithmetic, %0d unused codes), %0d words checked",
                 n_push + n_arith + n_unused, n_push, n_arith, n_unused, checked);
        $display("underflow %0d, overflow %0d, divide by zero %0d, deepest stack %0d",
                 n_underflow, n_overflow, n_divzero, deepest);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/smalu_pkg.sv
hw/rtl/smalu_cell.sv
hw/rtl/smalu_div.sv
hw/rtl/stack_machine_integer_alu_top.sv
hw/rtl/smalu_chk.sv
sim/testbench.sv
